FILE: src/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic        [16:0] pressure_centi_mbar;
    logic               saturated;
  } out_t;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_PRESSURE_SENSITIVITY = 3'd0;
  localparam cfg_idx_t CFG_PRESSURE_OFFSET      = 3'd1;
  localparam cfg_idx_t CFG_SENSITIVITY_TEMP     = 3'd2;
  localparam cfg_idx_t CFG_OFFSET_TEMP          = 3'd3;
  localparam cfg_idx_t CFG_REFERENCE_TEMP       = 3'd4;
  localparam cfg_idx_t CFG_TEMPERATURE_SLOPE    = 3'd5;

  localparam int TEMP_REF  = 2000;
  localparam int TEMP_VLOW = -1500;
  localparam int TEMP_MIN  = -4000;
  localparam int TEMP_MAX  = 8500;
  localparam int PRES_MIN  = 1000;
  localparam int PRES_MAX  = 120000;

endpackage

`default_nettype wire

FILE: src/barometric_pressure_compensation_core.sv
`default_nettype none

// channel   signals                         beat carries
// -------   ------------------------------  --------------------------------------
// in        in_valid, in_stall, in_data     raw pressure and raw temperature
// out       out_valid, out_stall, out_data  temperature, pressure, saturated flag
// cfg       cfg_we, cfg_index, cfg_data     one 16-bit calibration word
//
// nine register stages, one beat in per cycle while in_stall is low; a result leaves from the ninth stage
// the stage chain is set by the wide pressure product, split into two partial products
// rst is synchronous and clears the stage valid bits and the calibration words
// a stalled output holds; bubbles are squeezed out, so in_stall rises only when all
// nine stages hold a beat

module barometric_pressure_compensation_core (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  bpc_pkg::in_t       in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output bpc_pkg::out_t            out_data,
  input  wire                      cfg_we,
  input  wire  bpc_pkg::cfg_idx_t  cfg_index,
  input  wire               [15:0] cfg_data
);
  import bpc_pkg::*;

  localparam int NSTG = 9;

  logic [15:0] pressure_sensitivity_coeff;
  logic [15:0] pressure_offset_coeff;
  logic [15:0] sensitivity_temp_coeff;
  logic [15:0] offset_temp_coeff;
  logic [15:0] reference_temperature;
  logic [15:0] temperature_slope_coeff;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_sensitivity_coeff <= '0;
      pressure_offset_coeff      <= '0;
      sensitivity_temp_coeff     <= '0;
      offset_temp_coeff          <= '0;
      reference_temperature      <= '0;
      temperature_slope_coeff    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESSURE_SENSITIVITY: pressure_sensitivity_coeff <= cfg_data;
        CFG_PRESSURE_OFFSET:      pressure_offset_coeff      <= cfg_data;
        CFG_SENSITIVITY_TEMP:     sensitivity_temp_coeff     <= cfg_data;
        CFG_OFFSET_TEMP:          offset_temp_coeff          <= cfg_data;
        CFG_REFERENCE_TEMP:       reference_temperature      <= cfg_data;
        CFG_TEMPERATURE_SLOPE:    temperature_slope_coeff    <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or its content moves on
  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: dT
  logic signed [24:0] s1_dt;
  logic        [23:0] s1_d1;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_dt <= $signed({1'b0, in_data.raw_temperature})
             - $signed({1'b0, reference_temperature, 8'b0});
      s1_d1 <= in_data.raw_pressure;
    end
  end

  // stage 2: the four products of dT
  logic signed [41:0] s2_pt;
  logic signed [41:0] s2_po;
  logic signed [41:0] s2_ps;
  logic signed [49:0] s2_dd;
  logic        [23:0] s2_d1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_pt <= s1_dt * $signed({1'b0, temperature_slope_coeff});
      s2_po <= s1_dt * $signed({1'b0, offset_temp_coeff});
      s2_ps <= s1_dt * $signed({1'b0, sensitivity_temp_coeff});
      s2_dd <= s1_dt * s1_dt;
      s2_d1 <= s1_d1;
    end
  end

  // stage 3: first-order TEMP, OFF, SENS; deltas for the low-temperature terms
  logic signed [18:0] s3_a;
  logic signed [19:0] s3_b;
  logic signed [19:0] s3_temp;
  logic signed [35:0] s3_off;
  logic signed [35:0] s3_sens;
  logic        [17:0] s3_t2;
  logic               s3_low;
  logic               s3_vlow;
  logic        [23:0] s3_d1;

  logic signed [18:0] tsh;
  logic signed [19:0] bsum;

  always_comb begin
    tsh  = $signed(s2_pt[41:23]);
    bsum = tsh + 20'(TEMP_REF - TEMP_VLOW);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_a    <= tsh;
      s3_b    <= bsum;
      s3_temp <= tsh + 20'(TEMP_REF);
      s3_off  <= $signed({4'b0, pressure_offset_coeff, 16'b0}) + $signed(s2_po[41:7]);
      s3_sens <= $signed({5'b0, pressure_sensitivity_coeff, 15'b0})
               + $signed(s2_ps[41:8]);
      s3_t2   <= s2_dd[48:31];
      s3_low  <= tsh[18];
      s3_vlow <= bsum[19];
      s3_d1   <= s2_d1;
    end
  end

  // stage 4: squares
  logic        [36:0] s4_aa;
  logic        [36:0] s4_bb;
  logic signed [19:0] s4_temp;
  logic signed [35:0] s4_off;
  logic signed [35:0] s4_sens;
  logic        [17:0] s4_t2;
  logic               s4_low;
  logic               s4_vlow;
  logic        [23:0] s4_d1;

  logic signed [37:0] aa_full;
  logic signed [39:0] bb_full;

  always_comb begin
    aa_full = s3_a * s3_a;
    bb_full = s3_b * s3_b;
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_aa   <= aa_full[36:0];
      // only used below -15 C, where the square fits
      s4_bb   <= bb_full[36:0];
      s4_temp <= s3_temp;
      s4_off  <= s3_off;
      s4_sens <= s3_sens;
      s4_t2   <= s3_t2;
      s4_low  <= s3_low;
      s4_vlow <= s3_vlow;
      s4_d1   <= s3_d1;
    end
  end

  // stage 5: OFF2, SENS2 and the corrected temperature
  logic        [40:0] s5_off2;
  logic        [40:0] s5_sens2;
  logic signed [20:0] s5_temp;
  logic signed [35:0] s5_off;
  logic signed [35:0] s5_sens;
  logic        [23:0] s5_d1;

  logic [40:0] aa5;
  logic [40:0] bb7;
  logic [40:0] bb11;
  logic [40:0] off2;
  logic [40:0] sens2;

  always_comb begin
    aa5   = {2'b0, s4_aa, 2'b0} + {4'b0, s4_aa};
    bb7   = {1'b0, s4_bb, 3'b0} - {4'b0, s4_bb};
    bb11  = {1'b0, s4_bb, 3'b0} + {3'b0, s4_bb, 1'b0} + {4'b0, s4_bb};
    off2  = (aa5 >> 1) + (s4_vlow ? bb7 : '0);
    sens2 = (aa5 >> 2) + (s4_vlow ? (bb11 >> 1) : '0);
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_off2  <= s4_low ? off2 : '0;
      s5_sens2 <= s4_low ? sens2 : '0;
      s5_temp  <= s4_low ? 21'(s4_temp) - $signed({3'b0, s4_t2}) : 21'(s4_temp);
      s5_off   <= s4_off;
      s5_sens  <= s4_sens;
      s5_d1    <= s4_d1;
    end
  end

  // stage 6: final OFF and SENS, temperature clamp
  logic signed [41:0] s6_off;
  logic signed [41:0] s6_sens;
  logic signed [14:0] s6_temp;
  logic               s6_tsat;
  logic        [23:0] s6_d1;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_off  <= s5_off - $signed({1'b0, s5_off2});
      s6_sens <= s5_sens - $signed({1'b0, s5_sens2});
      s6_d1   <= s5_d1;
      if (s5_temp < TEMP_MIN) begin
        s6_temp <= 15'(TEMP_MIN);
        s6_tsat <= 1'b1;
      end else if (s5_temp > TEMP_MAX) begin
        s6_temp <= 15'(TEMP_MAX);
        s6_tsat <= 1'b1;
      end else begin
        s6_temp <= s5_temp[14:0];
        s6_tsat <= 1'b0;
      end
    end
  end

  // stage 7: D1 * SENS as two partial products
  logic        [44:0] s7_pl;
  logic signed [45:0] s7_ph;
  logic signed [41:0] s7_off;
  logic signed [14:0] s7_temp;
  logic               s7_tsat;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s7_pl   <= s6_d1 * s6_sens[20:0];
      s7_ph   <= $signed({1'b0, s6_d1}) * $signed(s6_sens[41:21]);
      s7_off  <= s6_off;
      s7_temp <= s6_temp;
      s7_tsat <= s6_tsat;
    end
  end

  // stage 8: combine partial products, >> 21
  logic signed [45:0] s8_q;
  logic signed [41:0] s8_off;
  logic signed [14:0] s8_temp;
  logic               s8_tsat;

  logic signed [66:0] prod;

  always_comb begin
    prod = $signed({s7_ph, 21'b0}) + $signed({22'b0, s7_pl});
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s8_q    <= prod[66:21];
      s8_off  <= s7_off;
      s8_temp <= s7_temp;
      s8_tsat <= s7_tsat;
    end
  end

  // stage 9: subtract OFF, >> 15, pressure clamp into the output register
  logic signed [46:0] pdiff;
  logic signed [31:0] pres;

  always_comb begin
    pdiff = s8_q - s8_off;
    pres  = $signed(pdiff[46:15]);
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      out_data.temperature_centi <= s8_temp;
      if (pres < PRES_MIN) begin
        out_data.pressure_centi_mbar <= 17'(PRES_MIN);
        out_data.saturated           <= 1'b1;
      end else if (pres > PRES_MAX) begin
        out_data.pressure_centi_mbar <= 17'(PRES_MAX);
        out_data.saturated           <= 1'b1;
      end else begin
        out_data.pressure_centi_mbar <= pres[16:0];
        out_data.saturated           <= s8_tsat;
      end
    end
  end

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.temperature_centi >= TEMP_MIN
                   && out_data.temperature_centi <= TEMP_MAX))
    else $error("temperature outside clamp range");

  a_pres_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.pressure_centi_mbar >= PRES_MIN
                   && out_data.pressure_centi_mbar <= PRES_MAX))
    else $error("pressure outside clamp range");

  a_full_on_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld))
    else $error("input stalled while a stage is empty");

  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && !adv[4]) |=> vld[4])
    else $error("held beat lost in mid pipeline");

endmodule

`default_nettype wire
